[hdl/acs_pkg.sv]
// Shared types, codes and constants of the arm cycle sequencer.
// No dependencies; every other file imports this package.
package acs_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic REG_STEP_TICKS   = 1'b0;
    localparam logic REG_FINISH_TICKS = 1'b1;

    localparam logic [7:0] STEP_TICKS_RST   = 8'd10;
    localparam logic [7:0] FINISH_TICKS_RST = 8'd20;
    localparam logic [2:0] AUTO_IDLE        = 3'd5;

    localparam int LB_UP    = 0;
    localparam int LB_FWD   = 1;
    localparam int LB_INJ1  = 2;
    localparam int LB_INJ2  = 3;
    localparam int LB_TURN  = 4;
    localparam int LB_DONE  = 5;
    localparam int LB_FAULT = 6;

    localparam int MP_TURNED = 0;
    localparam int MP_BLOWN1 = 1;
    localparam int MP_BLOWN2 = 2;

    localparam logic [2:0] FC_NONE      = 3'd0;
    localparam logic [2:0] FC_UPDOWN    = 3'd1;
    localparam logic [2:0] FC_FRONTBACK = 3'd2;
    localparam logic [2:0] FC_UP        = 3'd3;
    localparam logic [2:0] FC_FRONT     = 3'd4;
    localparam logic [2:0] FC_DOWN      = 3'd5;
    localparam logic [2:0] FC_BACK      = 3'd6;

    localparam logic [3:0] PC_WAIT   = 4'd0;
    localparam logic [3:0] PC_UP     = 4'd1;
    localparam logic [3:0] PC_FRONT  = 4'd2;
    localparam logic [3:0] PC_TURN   = 4'd3;
    localparam logic [3:0] PC_DOWN   = 4'd4;
    localparam logic [3:0] PC_BLOW   = 4'd5;
    localparam logic [3:0] PC_BACK   = 4'd6;
    localparam logic [3:0] PC_FINISH = 4'd7;
    localparam logic [3:0] PC_FAULT  = 4'd8;

    typedef enum logic [4:0] {
        PH_WAIT, PH_A_UP, PH_A_FRONT, PH_A_TURN, PH_A_DOWN, PH_A_BLOW1,
        PH_A_BACK, PH_A_BACKERR, PH_A_BLOW2, PH_A_TURN2, PH_A_FINISH,
        PH_M_UP, PH_M_FRONT, PH_M_TURN, PH_M_DOWN, PH_M_BLOW1, PH_M_BACK,
        PH_M_BLOW2, PH_M_TURN2, PH_FAULT
    } t_phase;

    typedef struct packed {
        logic reset_req;
        logic auto_req;
        logic manual_req;
        logic arm_up;
        logic arm_down;
        logic arm_forward;
        logic arm_backward;
    } t_tick;

    typedef struct packed {
        logic [7:0] step_ticks;
        logic [7:0] finish_ticks;
    } t_cfg;

    typedef struct packed {
        t_phase     phase;
        logic [7:0] tick_count;
        logic [2:0] last_auto_step;
        logic [2:0] manual_progress;
        logic [6:0] latches;
        logic [2:0] fault_reason;
    } t_seq_state;

    function automatic logic [3:0] f_phase_code(t_phase p);
        logic [3:0] c;
        case (p)
            PH_WAIT:      c = PC_WAIT;
            PH_A_UP:      c = PC_UP;
            PH_A_FRONT:   c = PC_FRONT;
            PH_A_TURN:    c = PC_TURN;
            PH_A_DOWN:    c = PC_DOWN;
            PH_A_BLOW1:   c = PC_BLOW;
            PH_A_BACK:    c = PC_BACK;
            PH_A_BACKERR: c = PC_FAULT;
            PH_A_BLOW2:   c = PC_BLOW;
            PH_A_TURN2:   c = PC_TURN;
            PH_A_FINISH:  c = PC_FINISH;
            PH_M_UP:      c = PC_UP;
            PH_M_FRONT:   c = PC_FRONT;
            PH_M_TURN:    c = PC_TURN;
            PH_M_DOWN:    c = PC_DOWN;
            PH_M_BLOW1:   c = PC_BLOW;
            PH_M_BACK:    c = PC_BACK;
            PH_M_BLOW2:   c = PC_BLOW;
            PH_M_TURN2:   c = PC_TURN;
            PH_FAULT:     c = PC_FAULT;
            default:      c = PC_WAIT;
        endcase
        return c;
    endfunction

endpackage

[hdl/acs_cfg_regs.sv]
// APB-style configuration registers: phase length and finish hold time.
// Depends on acs_pkg.
module acs_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [acs_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [acs_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [acs_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready,
    output acs_pkg::t_cfg                    o_cfg
);
    import acs_pkg::*;

    logic [7:0] r_step_ticks;
    logic [7:0] r_finish_ticks;
    logic       wr_en;
    logic       reg_sel;

    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_ticks   <= STEP_TICKS_RST;
            r_finish_ticks <= FINISH_TICKS_RST;
        end else if (wr_en) begin
            if (reg_sel == REG_STEP_TICKS) begin
                r_step_ticks <= pwdata[7:0];
            end else begin
                r_finish_ticks <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        if (reg_sel == REG_STEP_TICKS) begin
            prdata = {{(CFG_DATA_W-8){1'b0}}, r_step_ticks};
        end else begin
            prdata = {{(CFG_DATA_W-8){1'b0}}, r_finish_ticks};
        end
    end

    assign o_cfg.step_ticks   = r_step_ticks;
    assign o_cfg.finish_ticks = r_finish_ticks;

endmodule

[hdl/acs_seq_core.sv]
// Sequencer state register and its single-pass next-state logic.
// The state register doubles as the result register. Depends on acs_pkg.
module acs_seq_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  acs_pkg::t_tick      i_tick,
    input  acs_pkg::t_cfg       i_cfg,
    output acs_pkg::t_seq_state o_state
);
    import acs_pkg::*;

    localparam int NUM_STEPS = 13;

    localparam logic [3:0] STP_A_UP    = 4'd0;
    localparam logic [3:0] STP_A_FRONT = 4'd1;
    localparam logic [3:0] STP_A_TURN  = 4'd2;
    localparam logic [3:0] STP_A_BLOW1 = 4'd3;
    localparam logic [3:0] STP_A_BLOW2 = 4'd4;
    localparam logic [3:0] STP_M_UP    = 4'd5;
    localparam logic [3:0] STP_M_FRONT = 4'd6;
    localparam logic [3:0] STP_M_TURN  = 4'd7;
    localparam logic [3:0] STP_M_DOWN  = 4'd8;
    localparam logic [3:0] STP_M_BLOW1 = 4'd9;
    localparam logic [3:0] STP_M_BACK  = 4'd10;
    localparam logic [3:0] STP_M_BLOW2 = 4'd11;
    localparam logic [3:0] STP_M_TURN2 = 4'd12;

    localparam t_seq_state SEQ_RESET = '{
        phase:           PH_WAIT,
        tick_count:      8'd0,
        last_auto_step:  AUTO_IDLE,
        manual_progress: 3'd0,
        latches:         7'd0,
        fault_reason:    FC_NONE
    };

    t_seq_state r_state;
    t_seq_state n_state;
    logic [7:0] lim;
    logic [8:0] cnt;

    function automatic t_seq_state f_enter(t_seq_state s, t_phase p);
        t_seq_state r;
        r            = s;
        r.phase      = p;
        r.tick_count = 8'd0;
        return r;
    endfunction

    function automatic t_seq_state f_raise(t_seq_state s, logic [2:0] cause);
        t_seq_state r;
        r                   = s;
        r.fault_reason      = cause;
        r.latches[LB_FAULT] = 1'b1;
        r.phase             = PH_FAULT;
        return r;
    endfunction

    function automatic t_seq_state f_finish(t_seq_state s);
        t_seq_state r;
        r                  = s;
        r.latches[LB_TURN] = 1'b0;
        r.latches[LB_FWD]  = 1'b0;
        r.latches[LB_INJ1] = 1'b0;
        r.latches[LB_INJ2] = 1'b0;
        r.latches[LB_DONE] = 1'b1;
        r.last_auto_step   = AUTO_IDLE;
        return r;
    endfunction

    function automatic logic [NUM_STEPS-1:0] f_ok(t_seq_state s, t_tick t);
        logic fresh;
        logic tn;
        logic b1;
        logic b2;
        logic [NUM_STEPS-1:0] ok;
        fresh = (s.manual_progress == 3'd0);
        tn    = s.manual_progress[MP_TURNED];
        b1    = s.manual_progress[MP_BLOWN1];
        b2    = s.manual_progress[MP_BLOWN2];
        ok[STP_A_UP]    = t.arm_down && (s.last_auto_step == 3'd5) && t.arm_backward;
        ok[STP_A_FRONT] = t.arm_up && (s.last_auto_step == 3'd1) && t.arm_backward;
        ok[STP_A_TURN]  = t.arm_forward && (s.last_auto_step == 3'd2) && t.arm_up;
        ok[STP_A_BLOW1] = t.arm_down && (s.last_auto_step == 3'd3) && t.arm_forward;
        ok[STP_A_BLOW2] = t.arm_backward && (s.last_auto_step == 3'd4);
        ok[STP_M_UP]    = t.manual_req && t.arm_down && t.arm_backward && fresh;
        ok[STP_M_FRONT] = t.manual_req && t.arm_up && t.arm_backward && fresh;
        ok[STP_M_TURN]  = t.manual_req && t.arm_forward && t.arm_up && fresh;
        ok[STP_M_DOWN]  = t.manual_req && t.arm_up && t.arm_forward && tn && !b1 && !b2;
        ok[STP_M_BLOW1] = t.manual_req && t.arm_down && t.arm_forward && tn && !b1 && !b2;
        ok[STP_M_BACK]  = t.manual_req && t.arm_down && t.arm_forward && tn && b1 && !b2;
        ok[STP_M_BLOW2] = t.manual_req && t.arm_down && t.arm_backward && tn && b1 && !b2;
        ok[STP_M_TURN2] = t.manual_req && t.arm_down && t.arm_backward && tn && b1 && b2;
        return ok;
    endfunction

    function automatic t_seq_state f_begin(t_seq_state s, logic [3:0] k);
        t_seq_state r;
        r = s;
        case (k)
            STP_A_UP: begin
                r.last_auto_step = 3'd1;
                r.latches[LB_UP] = 1'b1;
                r = f_enter(r, PH_A_UP);
            end
            STP_A_FRONT: begin
                r.last_auto_step  = 3'd2;
                r.latches[LB_FWD] = 1'b1;
                r = f_enter(r, PH_A_FRONT);
            end
            STP_A_TURN: begin
                r.latches[LB_TURN] = 1'b1;
                r = f_enter(r, PH_A_TURN);
            end
            STP_A_BLOW1: begin
                r.latches[LB_INJ1] = 1'b1;
                r = f_enter(r, PH_A_BLOW1);
            end
            STP_A_BLOW2: begin
                r.latches[LB_INJ2] = 1'b1;
                r = f_enter(r, PH_A_BLOW2);
            end
            STP_M_UP: begin
                r.latches[LB_UP] = 1'b1;
                r = f_enter(r, PH_M_UP);
            end
            STP_M_FRONT: begin
                r.latches[LB_FWD] = 1'b1;
                r = f_enter(r, PH_M_FRONT);
            end
            STP_M_TURN: begin
                r.latches[LB_TURN] = 1'b1;
                r = f_enter(r, PH_M_TURN);
            end
            STP_M_DOWN: begin
                r.latches[LB_UP] = 1'b0;
                r = f_enter(r, PH_M_DOWN);
            end
            STP_M_BLOW1: begin
                r.latches[LB_INJ1] = 1'b1;
                r = f_enter(r, PH_M_BLOW1);
            end
            STP_M_BACK: begin
                r.latches[LB_FWD] = 1'b0;
                r = f_enter(r, PH_M_BACK);
            end
            STP_M_BLOW2: begin
                r.latches[LB_INJ2] = 1'b1;
                r = f_enter(r, PH_M_BLOW2);
            end
            default: begin
                r.latches[LB_TURN] = 1'b1;
                r = f_enter(r, PH_M_TURN2);
            end
        endcase
        return r;
    endfunction

    // start the first step from k_from on whose conditions hold, else wait
    function automatic t_seq_state f_continue(t_seq_state s, t_tick t,
                                              logic [3:0] k_from);
        logic [NUM_STEPS-1:0] ok;
        logic                 found;
        logic [3:0]           sel;
        t_seq_state           r;
        ok    = f_ok(s, t);
        found = 1'b0;
        sel   = STP_A_UP;
        for (int i = 0; i < NUM_STEPS; i++) begin
            if (!found && (4'(i) >= k_from) && ok[i]) begin
                found = 1'b1;
                sel   = 4'(i);
            end
        end
        if (found) begin
            r = f_begin(s, sel);
        end else begin
            r = f_enter(s, PH_WAIT);
        end
        return r;
    endfunction

    function automatic t_seq_state f_phase_end(t_seq_state s, t_tick t);
        t_seq_state r;
        r = s;
        case (s.phase)
            PH_A_UP: begin
                if (!t.arm_up && t.auto_req) r = f_raise(s, FC_UP);
                else r = f_continue(s, t, STP_A_FRONT);
            end
            PH_A_FRONT: begin
                if (!t.arm_forward && t.auto_req) r = f_raise(s, FC_FRONT);
                else r = f_continue(s, t, STP_A_TURN);
            end
            PH_A_TURN: begin
                r.latches[LB_TURN] = 1'b0;
                r.latches[LB_UP]   = 1'b0;
                r.last_auto_step   = 3'd3;
                r = f_enter(r, PH_A_DOWN);
            end
            PH_A_DOWN: begin
                if (!t.arm_down && t.auto_req) r = f_raise(s, FC_DOWN);
                else r = f_continue(s, t, STP_A_BLOW1);
            end
            PH_A_BLOW1: begin
                r.latches[LB_INJ1] = 1'b0;
                r.latches[LB_FWD]  = 1'b0;
                r.last_auto_step   = 3'd4;
                r = f_enter(r, PH_A_BACK);
            end
            PH_A_BACK: begin
                if (!t.arm_backward && t.auto_req) begin
                    r.fault_reason = FC_BACK;
                    r = f_enter(r, PH_A_BACKERR);
                end else begin
                    r = f_continue(s, t, STP_A_BLOW2);
                end
            end
            PH_A_BACKERR: r = f_raise(s, FC_BACK);
            PH_A_BLOW2: begin
                r.latches[LB_INJ2] = 1'b0;
                r.latches[LB_TURN] = 1'b1;
                r = f_enter(r, PH_A_TURN2);
            end
            PH_A_TURN2: r = f_enter(f_finish(s), PH_A_FINISH);
            PH_A_FINISH: r = f_continue(s, t, STP_M_UP);
            PH_M_UP:     r = f_continue(s, t, STP_M_FRONT);
            PH_M_FRONT:  r = f_continue(s, t, STP_M_TURN);
            PH_M_TURN: begin
                r.latches[LB_TURN]            = 1'b0;
                r.manual_progress[MP_TURNED] = 1'b1;
                r = f_continue(r, t, STP_M_DOWN);
            end
            PH_M_DOWN: r = f_continue(s, t, STP_M_BLOW1);
            PH_M_BLOW1: begin
                r.latches[LB_INJ1]            = 1'b0;
                r.manual_progress[MP_BLOWN1] = 1'b1;
                r = f_continue(r, t, STP_M_BACK);
            end
            PH_M_BACK: r = f_continue(s, t, STP_M_BLOW2);
            PH_M_BLOW2: begin
                r.latches[LB_INJ2]            = 1'b0;
                r.manual_progress[MP_BLOWN2] = 1'b1;
                r = f_continue(r, t, STP_M_TURN2);
            end
            default: begin
                r                 = f_finish(s);
                r.manual_progress = 3'd0;
                r = f_enter(r, PH_WAIT);
            end
        endcase
        return r;
    endfunction

    always_comb begin
        lim = (r_state.phase == PH_A_FINISH) ? i_cfg.finish_ticks : i_cfg.step_ticks;
        if (lim == 8'd0) lim = 8'd1;
        cnt     = {1'b0, r_state.tick_count} + 9'd1;
        n_state = r_state;
        if (i_tick.reset_req) begin
            n_state = SEQ_RESET;
        end else if (r_state.phase == PH_WAIT) begin
            if (i_tick.auto_req || i_tick.manual_req) begin
                n_state.latches[LB_DONE] = 1'b0;
                if (i_tick.arm_up == i_tick.arm_down) begin
                    n_state = f_raise(n_state, FC_UPDOWN);
                end else if (i_tick.arm_forward == i_tick.arm_backward) begin
                    n_state = f_raise(n_state, FC_FRONTBACK);
                end else begin
                    n_state = f_continue(n_state, i_tick,
                                         i_tick.auto_req ? STP_A_UP : STP_M_UP);
                end
            end
        end else if (r_state.phase != PH_FAULT) begin
            n_state.tick_count = cnt[7:0];
            if (cnt >= {1'b0, lim}) n_state = f_phase_end(n_state, i_tick);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_RESET;
        end else if (i_en) begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule

[hdl/arm_cycle_sequencer_top.sv]
// Arm cycle sequencer: tick-driven controller for a two-axis arm.
// Input register, handshake control and result mapping.
// Depends on acs_pkg, acs_cfg_regs and acs_seq_core.
//
// Usage:
//   Each request on the input channel (i_valid/o_ready) is one timer tick
//   carrying the button levels and limit switches. Each tick yields exactly
//   one result on the output channel (o_valid/i_ready): the seven output
//   levels, the phase code and the fault cause, as they stand after the tick.
//   A request passes the input register, then one pass of next-state logic
//   into the sequencer state, which also serves as the result register.
//   o_valid rises when the state register takes the request; one request can be
//   accepted every cycle while results are taken every cycle.
//   When the receiver stalls the result holds, the state holds, and at most
//   one further request waits in the input register before o_ready drops.
//   At reset the sequencer waits for a start with all outputs off, and the
//   phase length and finish hold registers return to 10 and 20 ticks.
//   Write the registers over the APB port only while no request is in flight.
module arm_cycle_sequencer_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [acs_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [acs_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [acs_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_reset_req,
    input  logic                             i_auto_req,
    input  logic                             i_manual_req,
    input  logic                             i_arm_up,
    input  logic                             i_arm_down,
    input  logic                             i_arm_forward,
    input  logic                             i_arm_backward,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic                             o_drive_up,
    output logic                             o_drive_forward,
    output logic                             o_inject_one,
    output logic                             o_inject_two,
    output logic                             o_drive_turn,
    output logic                             o_done_res,
    output logic                             o_fault_lamp,
    output logic [3:0]                       o_phase_code,
    output logic [2:0]                       o_fault_cause
);
    import acs_pkg::*;

    t_cfg       cfg;
    t_seq_state state;
    t_tick      r_tick;
    logic       r_in_valid;
    logic       r_out_valid;
    logic       advance;

    acs_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) r_in_valid <= i_valid;
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_tick <= '{
                reset_req:    i_reset_req,
                auto_req:     i_auto_req,
                manual_req:   i_manual_req,
                arm_up:       i_arm_up,
                arm_down:     i_arm_down,
                arm_forward:  i_arm_forward,
                arm_backward: i_arm_backward
            };
        end
    end

    acs_seq_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_tick  (r_tick),
        .i_cfg   (cfg),
        .o_state (state)
    );

    assign o_valid         = r_out_valid;
    assign o_drive_up      = state.latches[LB_UP];
    assign o_drive_forward = state.latches[LB_FWD];
    assign o_inject_one    = state.latches[LB_INJ1];
    assign o_inject_two    = state.latches[LB_INJ2];
    assign o_drive_turn    = state.latches[LB_TURN];
    assign o_done_res      = state.latches[LB_DONE];
    assign o_fault_lamp    = state.latches[LB_FAULT];
    assign o_phase_code    = f_phase_code(state.phase);
    assign o_fault_cause   = state.fault_reason;

endmodule

[hdl/acs_checker.sv]
// Port-level checks of the arm cycle sequencer, bound to the top level.
// Depends on acs_pkg and arm_cycle_sequencer_top.
module acs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_fault_lamp,
    input logic [3:0] o_phase_code,
    input logic [2:0] o_fault_cause
);
    import acs_pkg::*;

    a_lamp_in_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_fault_lamp |-> o_phase_code == PC_FAULT)
        else $error("fault lamp lit outside fault phase");

    a_cause_only_in_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_phase_code != PC_FAULT |-> o_fault_cause == FC_NONE)
        else $error("fault cause reported outside fault phase");

    a_fault_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_phase_code == PC_FAULT |-> o_fault_cause != FC_NONE)
        else $error("fault phase without a cause");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_phase_code)
            && $stable(o_fault_cause) && $stable(o_fault_lamp))
        else $error("stalled result changed");

endmodule

bind arm_cycle_sequencer_top acs_checker u_acs_checker (.*);
